// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the local clk, masked while rst_n is low
`define SWARQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked in the same cycle
`define SWARQ_ASSERT_IMPL(label, ante, cons, msg) \
  `SWARQ_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ----- rtl/swarq_pkg.sv -----
`timescale 1ns / 1ps

package swarq_pkg;

  localparam int SEQ_W      = 8;
  localparam int TMO_W      = 16;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  localparam logic [TMO_W-1:0] MIN_TMO_RST = 16'd10;
  localparam logic [TMO_W-1:0] MAX_TMO_RST = 16'd1000;
  localparam logic [SEQ_W-1:0] RX_SEQ_RST  = 8'd255;

  typedef enum logic [MODE_W-1:0] {
    MODE_SEND_NEW   = 3'd0,
    MODE_ACK_IN     = 3'd1,
    MODE_DATA_IN    = 3'd2,
    MODE_TICK       = 3'd3,
    MODE_LINK_RESET = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_TIMEOUT    = 2'd0,
    CFG_MAX_TIMEOUT    = 2'd1,
    CFG_LINK_CONNECTED = 2'd2
  } cfg_idx_e;

  // mode in the low bits
  typedef struct packed {
    logic [SEQ_W-1:0]  seq_in;
    logic [MODE_W-1:0] mode;
  } item_t;

  // send_accepted in the low bits
  typedef struct packed {
    logic              waiting_ack;
    logic              timeout_capped;
    logic [TMO_W-1:0]  timeout_armed;
    logic              seq_gap;
    logic              deliver;
    logic [SEQ_W-1:0]  ack_seq;
    logic              send_ack;
    logic [SEQ_W-1:0]  tx_seq_out;
    logic              transmit;
    logic              send_accepted;
  } res_t;

  localparam int RES_W = $bits(res_t);

  typedef struct packed {
    logic [TMO_W-1:0] min_timeout;
    logic [TMO_W-1:0] max_timeout;
    logic             link_connected;
  } cfg_t;

  typedef struct packed {
    logic awaiting;
    logic timer_running;
  } status_t;

endpackage

// ----- rtl/stop_wait_arq_link.sv -----
`timescale 1ns / 1ps
//  channel  ports                        beat contents (lowest bit first)
//  input    in_tvalid/in_tready/in_tdata  mode[2:0], seq_in[10:3], zero pad
//  result   out_tvalid/out_tready/out_tdata
//                                         send_accepted, transmit, tx_seq_out,
//                                         send_ack, ack_seq, deliver, seq_gap,
//                                         timeout_armed, timeout_capped,
//                                         waiting_ack, zero pad
//  config   cfg_we/cfg_idx/cfg_wdata      write only, one register per beat
//
//  one beat per cycle while out_tready holds; input register, then
//  the link state update and result register in one pass
//  rst_n is synchronous, active low: link state and config to reset values
//  a stalled result holds out_tdata; the input register still takes a beat
//  while its slot is empty, so in_tready drops only when both stages are full

`include "assert_macros.svh"

module stop_wait_arq_link (
  input  logic                              clk,
  input  logic                              rst_n,
  // input beat: mode[2:0], seq_in[10:3]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [swarq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result beat: send_accepted[0], transmit[1], tx_seq_out[9:2], send_ack[10],
  // ack_seq[18:11], deliver[19], seq_gap[20], timeout_armed[36:21],
  // timeout_capped[37], waiting_ack[38]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [swarq_pkg::OUT_TDATA_W-1:0] out_tdata,
  // register writes
  input  logic                              cfg_we,
  input  logic [swarq_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [swarq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import swarq_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    advance;
  res_t    res;
  status_t status;

  // register file for timeouts and the connected flag
  swarq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input stage
  swarq_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // sequence, wait and backoff state plus result register
  swarq_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res),
    .status     (status)
  );

  // pad to whole bytes
  assign out_tdata = {{(OUT_TDATA_W-RES_W){1'b0}}, res};

  // a running timer always belongs to an outstanding frame
  `SWARQ_ASSERT_IMPL(a_run_implies_wait, status.timer_running, status.awaiting,
    "ack timer running while not waiting")
  // input back-pressure only comes from a stalled, full result stage
  `SWARQ_ASSERT_IMPL(a_stall_source, !in_tready, out_tvalid && !out_tready && item_valid,
    "input stalled without a blocked result")
  // an accepted send always orders a transmit and leaves the link waiting
  `SWARQ_ASSERT_IMPL(a_send_tx, out_tvalid && res.send_accepted,
    res.transmit && res.waiting_ack, "accepted send without transmit or wait")

endmodule

// ----- rtl/swarq_cfg.sv -----
`timescale 1ns / 1ps

module swarq_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [swarq_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [swarq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output swarq_pkg::cfg_t                 cfg
);
  import swarq_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_MIN_TIMEOUT:    cfg_nxt.min_timeout    = cfg_wdata[TMO_W-1:0];
        CFG_MAX_TIMEOUT:    cfg_nxt.max_timeout    = cfg_wdata[TMO_W-1:0];
        CFG_LINK_CONNECTED: cfg_nxt.link_connected = cfg_wdata[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_timeout    <= MIN_TMO_RST;
      cfg_r.max_timeout    <= MAX_TMO_RST;
      cfg_r.link_connected <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/swarq_in_reg.sv -----
`timescale 1ns / 1ps

module swarq_in_reg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [swarq_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                             advance,
  output logic                             item_valid,
  output swarq_pkg::item_t                 item
);
  import swarq_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // free slot, or the held item leaves this cycle
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_t'(in_tdata[$bits(item_t)-1:0]);
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- rtl/swarq_core.sv -----
`timescale 1ns / 1ps

module swarq_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  swarq_pkg::cfg_t        cfg,
  input  logic                   item_valid,
  input  swarq_pkg::item_t       item,
  output logic                   advance,
  output logic                   res_valid,
  input  logic                   res_ready,
  output swarq_pkg::res_t        res,
  output swarq_pkg::status_t     status
);
  import swarq_pkg::*;

  logic [SEQ_W-1:0] tx_seq_r,  tx_seq_nxt;
  logic [SEQ_W-1:0] rx_seq_r,  rx_seq_nxt;
  logic             await_r,   await_nxt;
  logic [TMO_W-1:0] cur_tmo_r, cur_tmo_nxt;
  logic [TMO_W-1:0] ticks_r,   ticks_nxt;
  logic             run_r,     run_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;

  assign advance = item_valid && (!out_valid_r || res_ready);

  always_comb begin
    logic             arm_req;
    logic [SEQ_W-1:0] diff;
    logic [TMO_W:0]   doubled;

    tx_seq_nxt  = tx_seq_r;
    rx_seq_nxt  = rx_seq_r;
    await_nxt   = await_r;
    cur_tmo_nxt = cur_tmo_r;
    ticks_nxt   = ticks_r;
    run_nxt     = run_r;
    res_nxt     = '0;
    arm_req     = 1'b0;
    diff        = item.seq_in - rx_seq_r;
    doubled     = {cur_tmo_r, 1'b0};

    case (item.mode)
      MODE_SEND_NEW: begin
        if (!await_r) begin
          tx_seq_nxt            = tx_seq_r + 1'b1;
          await_nxt             = 1'b1;
          res_nxt.send_accepted = 1'b1;
          res_nxt.transmit      = 1'b1;
          res_nxt.tx_seq_out    = tx_seq_r + 1'b1;
          arm_req               = 1'b1;
        end
      end
      MODE_ACK_IN: begin
        if (await_r && item.seq_in == tx_seq_r) begin
          await_nxt   = 1'b0;
          cur_tmo_nxt = '0;
          run_nxt     = 1'b0;
          ticks_nxt   = '0;
        end
      end
      MODE_DATA_IN: begin
        res_nxt.send_ack = 1'b1;
        res_nxt.ack_seq  = item.seq_in;
        if (item.seq_in != rx_seq_r) begin
          res_nxt.deliver = 1'b1;
          res_nxt.seq_gap = (diff > 8'd1);
          rx_seq_nxt      = item.seq_in;
        end
      end
      MODE_TICK: begin
        if (run_r) begin
          if (ticks_r <= 16'd1) begin
            ticks_nxt          = '0;
            run_nxt            = 1'b0;
            res_nxt.transmit   = 1'b1;
            res_nxt.tx_seq_out = tx_seq_r;
            arm_req            = 1'b1;
          end else begin
            ticks_nxt = ticks_r - 1'b1;
          end
        end
      end
      MODE_LINK_RESET: begin
        await_nxt = 1'b0;
        run_nxt   = 1'b0;
        ticks_nxt = '0;
      end
      default: begin
        res_nxt = '0;
      end
    endcase

    // backoff (connected link only): min while no timeout is held, then doubling up to the ceiling
    if (arm_req && cfg.link_connected) begin
      await_nxt = 1'b1;
      if (cur_tmo_r == '0) begin
        cur_tmo_nxt = cfg.min_timeout;
      end else if (doubled > {1'b0, cfg.max_timeout}) begin
        cur_tmo_nxt            = cfg.max_timeout;
        res_nxt.timeout_capped = 1'b1;
      end else begin
        cur_tmo_nxt = doubled[TMO_W-1:0];
      end
      ticks_nxt             = cur_tmo_nxt;
      run_nxt               = 1'b1;
      res_nxt.timeout_armed = cur_tmo_nxt;
    end

    res_nxt.waiting_ack = await_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_seq_r    <= '0;
      rx_seq_r    <= RX_SEQ_RST;
      await_r     <= 1'b0;
      cur_tmo_r   <= '0;
      ticks_r     <= '0;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        tx_seq_r  <= tx_seq_nxt;
        rx_seq_r  <= rx_seq_nxt;
        await_r   <= await_nxt;
        cur_tmo_r <= cur_tmo_nxt;
        ticks_r   <= ticks_nxt;
        run_r     <= run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid              = out_valid_r;
  assign res                    = res_r;
  assign status.awaiting        = await_r;
  assign status.timer_running   = run_r;

endmodule

// ----- sim/arq_link_checker.sv -----
`timescale 1ns / 1ps

// watches the three ports of the link controller, predicts every result beat
// and compares it field by field with what the block hands out
module arq_link_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [swarq_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [swarq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [swarq_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [swarq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               errors,
  output int                               outstanding,
  output logic [swarq_pkg::SEQ_W-1:0]       tx_seq_now
);
  import swarq_pkg::*;

  // register copies
  logic [TMO_W-1:0] cfg_min_tmo;
  logic [TMO_W-1:0] cfg_max_tmo;
  logic             cfg_connected;

  // link state
  logic [SEQ_W-1:0] link_tx_seq;
  logic [SEQ_W-1:0] link_rx_seq;
  logic             link_waiting;
  logic [TMO_W-1:0] backoff_tmo;
  logic [TMO_W-1:0] ticks_remaining;
  logic             timer_on;

  res_t expected_beats[$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  assign tx_seq_now = link_tx_seq;

  // arm the acknowledge timer when connected: min if none is held, else doubling from the last timeout
  task automatic arm_backoff(inout res_t r);
    logic [TMO_W:0] doubled;
    if (!cfg_connected) return;
    link_waiting = 1'b1;
    if (backoff_tmo == '0) begin
      backoff_tmo = cfg_min_tmo;
    end else begin
      doubled = {backoff_tmo, 1'b0};
      if (doubled > {1'b0, cfg_max_tmo}) begin
        doubled          = {1'b0, cfg_max_tmo};
        r.timeout_capped = 1'b1;
      end
      backoff_tmo = doubled[TMO_W-1:0];
    end
    ticks_remaining = backoff_tmo;
    timer_on        = 1'b1;
    r.timeout_armed = backoff_tmo;
  endtask

  task automatic predict_link(input item_t it, output res_t r);
    logic [SEQ_W-1:0] seq_dist;
    r = '0;
    case (it.mode)
      MODE_SEND_NEW: begin
        if (!link_waiting) begin
          link_tx_seq     = link_tx_seq + 1'b1;
          link_waiting    = 1'b1;
          r.send_accepted = 1'b1;
          r.transmit      = 1'b1;
          r.tx_seq_out    = link_tx_seq;
          arm_backoff(r);
        end
      end
      MODE_ACK_IN: begin
        if (link_waiting && it.seq_in == link_tx_seq) begin
          link_waiting    = 1'b0;
          backoff_tmo     = '0;
          timer_on        = 1'b0;
          ticks_remaining = '0;
        end
      end
      MODE_DATA_IN: begin
        r.send_ack = 1'b1;
        r.ack_seq  = it.seq_in;
        if (it.seq_in != link_rx_seq) begin
          seq_dist    = it.seq_in - link_rx_seq;
          r.deliver   = 1'b1;
          r.seq_gap   = (seq_dist > 1);
          link_rx_seq = it.seq_in;
        end
      end
      MODE_TICK: begin
        if (timer_on) begin
          if (ticks_remaining <= 1) begin
            ticks_remaining = '0;
            timer_on        = 1'b0;
            r.transmit      = 1'b1;
            r.tx_seq_out    = link_tx_seq;
            arm_backoff(r);
          end else begin
            ticks_remaining = ticks_remaining - 1'b1;
          end
        end
      end
      MODE_LINK_RESET: begin
        link_waiting    = 1'b0;
        timer_on        = 1'b0;
        ticks_remaining = '0;
      end
      default: ;
    endcase
    r.waiting_ack = link_waiting;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      cfg_min_tmo     = MIN_TMO_RST;
      cfg_max_tmo     = MAX_TMO_RST;
      cfg_connected   = 1'b0;
      link_tx_seq     = '0;
      link_rx_seq     = RX_SEQ_RST;
      link_waiting    = 1'b0;
      backoff_tmo     = '0;
      ticks_remaining = '0;
      timer_on        = 1'b0;
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MIN_TIMEOUT:    cfg_min_tmo   = cfg_wdata[TMO_W-1:0];
          CFG_MAX_TIMEOUT:    cfg_max_tmo   = cfg_wdata[TMO_W-1:0];
          CFG_LINK_CONNECTED: cfg_connected = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[RES_W-1:0];
        if (expected_beats.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, actual 0x%0h",
                   $time, out_tdata);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          check_field("send_accepted", 32'(want.send_accepted), 32'(got.send_accepted));
          check_field("transmit", 32'(want.transmit), 32'(got.transmit));
          check_field("tx_seq_out", 32'(want.tx_seq_out), 32'(got.tx_seq_out));
          check_field("send_ack", 32'(want.send_ack), 32'(got.send_ack));
          check_field("ack_seq", 32'(want.ack_seq), 32'(got.ack_seq));
          check_field("deliver", 32'(want.deliver), 32'(got.deliver));
          check_field("seq_gap", 32'(want.seq_gap), 32'(got.seq_gap));
          check_field("timeout_armed", 32'(want.timeout_armed), 32'(got.timeout_armed));
          check_field("timeout_capped", 32'(want.timeout_capped),
                      32'(got.timeout_capped));
          check_field("waiting_ack", 32'(want.waiting_ack), 32'(got.waiting_ack));
          check_field("padding", 0, 32'(out_tdata[OUT_TDATA_W-1:RES_W]));
        end
      end
      if (in_tvalid && in_tready) begin
        predict_link(item_t'(in_tdata[$bits(item_t)-1:0]), want);
        expected_beats.push_back(want);
      end
    end
    outstanding = expected_beats.size();
  end

endmodule

// ----- sim/stop_wait_arq_link_tb.sv -----
`timescale 1ns / 1ps

// stimulus and verdict for the stop-and-wait link controller; all checking
// lives in the checker instance beside the block
module stop_wait_arq_link_tb;
  import swarq_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // input beat: mode, seq_in, zero pad
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  // result beat: send_accepted, transmit, tx_seq_out, send_ack, ack_seq,
  // deliver, seq_gap, timeout_armed, timeout_capped, waiting_ack, zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int               errors;
  int               outstanding;
  logic [SEQ_W-1:0] tx_seq_now;

  // once set, neither side idles any more
  logic             calm;
  int               items_sent;
  // last data sequence handed to the block, mirrors its receive side
  logic [SEQ_W-1:0] rx_guess;
  int               ready_hold;

  stop_wait_arq_link uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  arq_link_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .outstanding (outstanding),
    .tx_seq_now  (tx_seq_now)
  );

  always #5 clk = ~clk;

  // hard stop well beyond the slowest correct run
  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver side: bursts of stall between runs of ready, none once calm
  always @(negedge clk) begin
    if (calm) begin
      out_tready = 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_tready = 1'b0;
      ready_hold = $urandom_range(1, 16) - 1;
    end else begin
      out_tready = 1'b1;
      ready_hold = $urandom_range(0, 24);
    end
  end

  // one input beat; returns at the falling edge after it was taken, with
  // tvalid still high so a following beat can go straight on
  task automatic push_item(input logic [MODE_W-1:0] mode, input logic [SEQ_W-1:0] seq);
    item_t it;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    it.mode   = mode;
    it.seq_in = seq;
    in_tdata  = IN_TDATA_W'(it);
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (mode == MODE_DATA_IN) rx_guess = seq;
  endtask

  // sender holds off until every result is back, plus a little slack
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_idx   = idx;
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_link(input logic [TMO_W-1:0] min_tmo, input logic [TMO_W-1:0] max_tmo,
                          input logic connected);
    wait_idle();
    write_reg(CFG_MIN_TIMEOUT, min_tmo);
    write_reg(CFG_MAX_TIMEOUT, max_tmo);
    write_reg(CFG_LINK_CONNECTED, CFG_DATA_W'(connected));
  endtask

  // mostly in-order data, with duplicates, skips and stray sequences
  task automatic data_item();
    int          pick;
    logic [SEQ_W-1:0] seq;
    pick = $urandom_range(0, 19);
    if (pick < 12)      seq = rx_guess + 1'b1;
    else if (pick < 15) seq = rx_guess;
    else if (pick < 18) seq = rx_guess + SEQ_W'($urandom_range(2, 255));
    else                seq = SEQ_W'($urandom);
    push_item(MODE_DATA_IN, seq);
  endtask

  // a send followed by ticks (expiry and backoff), then the way it ends
  task automatic run_exchange(input int max_ticks);
    int n;
    int pick;
    push_item(MODE_SEND_NEW, SEQ_W'($urandom));
    n = $urandom_range(0, max_ticks);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) data_item();
      else                           push_item(MODE_TICK, SEQ_W'($urandom));
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      push_item(MODE_ACK_IN, tx_seq_now);
    end else if (pick == 7) begin
      // stale or foreign ack first, ignored by the block
      push_item(MODE_ACK_IN, tx_seq_now ^ SEQ_W'($urandom_range(1, 255)));
      push_item(MODE_ACK_IN, tx_seq_now);
    end else if (pick == 8) begin
      push_item(MODE_LINK_RESET, SEQ_W'($urandom));
    end
    // otherwise left waiting: the next send is refused
  endtask

  task automatic random_phase(input int beats, input int max_ticks);
    int stop_at;
    int pick;
    stop_at = items_sent + beats;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)      run_exchange(max_ticks);
      else if (pick < 8) data_item();
      else               push_item(MODE_W'($urandom_range(0, 7)), SEQ_W'($urandom));
    end
  endtask

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b1;
    cfg_we     = 1'b0;
    cfg_idx    = CFG_MIN_TIMEOUT;
    cfg_wdata  = '0;
    calm       = 1'b0;
    items_sent = 0;
    rx_guess   = RX_SEQ_RST;
    ready_hold = 0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // --- directed: reset settings, link not connected ---
    // modes past link reset do nothing
    for (int k = 1; k <= 3; k++) push_item(MODE_W'(MODE_LINK_RESET + k), 8'hFF);
    push_item(MODE_TICK, 8'h00);         // tick with no timer
    push_item(MODE_ACK_IN, 8'h00);       // ack while not waiting
    push_item(MODE_DATA_IN, 8'hFF);      // repeat of the reset sequence
    push_item(MODE_DATA_IN, 8'h00);      // wraps to zero, no gap
    push_item(MODE_DATA_IN, 8'hC8);      // skip
    // send without a timer stays waiting until acked
    push_item(MODE_SEND_NEW, 8'h00);
    push_item(MODE_SEND_NEW, 8'h00);     // refused while waiting
    push_item(MODE_ACK_IN, tx_seq_now + 1'b1);
    push_item(MODE_ACK_IN, tx_seq_now);

    // zero-length timeout: expires on the first tick
    set_link(16'd0, 16'hFFFF, 1'b1);
    push_item(MODE_SEND_NEW, 8'hFF);
    push_item(MODE_TICK, 8'hFF);
    push_item(MODE_LINK_RESET, 8'h00);

    // largest timeout: the tick only counts it down, no expiry before the ack
    set_link(16'hFFFF, 16'hFFFF, 1'b1);
    push_item(MODE_SEND_NEW, 8'h00);
    push_item(MODE_TICK, 8'h00);
    push_item(MODE_ACK_IN, tx_seq_now);

    // ceiling lowered below the running timeout while waiting
    set_link(16'd2, 16'd100, 1'b1);
    push_item(MODE_SEND_NEW, 8'h00);
    repeat (2) push_item(MODE_TICK, 8'h00);
    wait_idle();
    write_reg(CFG_MAX_TIMEOUT, 16'd3);
    repeat (4) push_item(MODE_TICK, 8'h00);
    push_item(MODE_ACK_IN, tx_seq_now);

    // --- random phases, each starting from an idle block ---
    set_link(16'd1, 16'd8, 1'b1);
    random_phase(235, 24);
    set_link(16'd3, 16'd40, 1'b1);
    random_phase(235, 80);
    set_link(16'd0, 16'd6, 1'b1);
    random_phase(235, 12);
    set_link(16'd5, 16'd1, 1'b1);
    random_phase(235, 16);
    set_link(16'd1, 16'd1, 1'b0);
    random_phase(235, 8);
    set_link(16'hFFFF, 16'hFFFF, 1'b1);
    random_phase(120, 30);
    set_link(16'd1, 16'hFFFF, 1'b1);
    random_phase(235, 40);
    // last part runs without idling on either side
    set_link(16'd4, 16'd16, 1'b1);
    calm = 1'b1;
    random_phase(235, 40);

    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
